[hdl/fsst_pkg.sv]
// ----------------------------------------------------------------------------
// fsst_pkg - shared types and constants of the sun tracker control
// payload structs, register map, sleep causes and servo codes
// ----------------------------------------------------------------------------
package fsst_pkg;

  // field widths of the item payloads
  localparam int unsigned SampleW = 12;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CodeW   = 10;
  localparam int unsigned CauseW  = 2;

  // config register widths
  localparam int unsigned ThreshW = 13;
  localparam int unsigned MsW     = 16;

  // apb address width: seven registers at byte addresses 4*i
  localparam int unsigned AddrW = 5;
  localparam int unsigned DataW = 32;

  // default parameter values
  localparam int unsigned DefSampleBits = 12;
  localparam int unsigned DefTimeBits   = 32;

  // servo codes
  localparam logic [CodeW-1:0] PanRight  = CodeW'(67);
  localparam logic [CodeW-1:0] PanLeft   = CodeW'(85);
  localparam logic [CodeW-1:0] PanStop   = CodeW'(75);
  localparam logic [CodeW-1:0] TiltReset = CodeW'(125);

  // config register reset values
  localparam logic [ThreshW-1:0] ThreshReset   = ThreshW'(300);
  localparam logic [MsW-1:0]     IdleReset     = MsW'(5000);
  localparam logic [MsW-1:0]     ArmDelayReset = MsW'(1500);
  localparam logic [MsW-1:0]     HoldReset     = MsW'(2000);
  localparam logic [MsW-1:0]     MaxAwakeReset = MsW'(25000);
  localparam logic [CodeW-1:0]   TiltMinReset  = CodeW'(25);
  localparam logic [CodeW-1:0]   TiltMaxReset  = CodeW'(125);

  typedef enum logic [2:0] {
    RegThreshold = 3'd0,
    RegIdleTimeout = 3'd1,
    RegArmDelay = 3'd2,
    RegButtonHold = 3'd3,
    RegMaxAwake = 3'd4,
    RegTiltMin = 3'd5,
    RegTiltMax = 3'd6
  } reg_idx_e;

  typedef enum logic [CauseW-1:0] {
    CauseNone = 2'd0,
    CauseIdle = 2'd1,
    CauseButton = 2'd2,
    CauseAwake = 2'd3
  } sleep_cause_e;

  typedef struct packed {
    logic [SampleW-1:0] upper_left_level;
    logic [SampleW-1:0] lower_left_level;
    logic [SampleW-1:0] upper_right_level;
    logic [SampleW-1:0] lower_right_level;
    logic               button_level;
    logic [TimeW-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  pan_code;
    logic [CodeW-1:0]  tilt_code;
    logic              sleep_request;
    logic [CauseW-1:0] sleep_cause;
  } out_item_t;

  typedef struct packed {
    logic [ThreshW-1:0] balance_threshold;
    logic [MsW-1:0]     idle_timeout_ms;
    logic [MsW-1:0]     button_arm_delay_ms;
    logic [MsW-1:0]     button_hold_ms;
    logic [MsW-1:0]     max_awake_ms;
    logic [CodeW-1:0]   tilt_min_code;
    logic [CodeW-1:0]   tilt_max_code;
  } cfg_t;

endpackage

[hdl/fsst_regs.sv]
// ----------------------------------------------------------------------------
// fsst_regs - configuration register file
// apb-style write and read access to the seven control registers
// ----------------------------------------------------------------------------
module fsst_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsst_pkg::AddrW-1:0]   paddr,
  input  logic [fsst_pkg::DataW-1:0]   pwdata,
  output logic [fsst_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output fsst_pkg::cfg_t               cfg_o
);
  import fsst_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegThreshold:   cfg_d.balance_threshold   = pwdata[ThreshW-1:0];
        RegIdleTimeout: cfg_d.idle_timeout_ms     = pwdata[MsW-1:0];
        RegArmDelay:    cfg_d.button_arm_delay_ms = pwdata[MsW-1:0];
        RegButtonHold:  cfg_d.button_hold_ms      = pwdata[MsW-1:0];
        RegMaxAwake:    cfg_d.max_awake_ms        = pwdata[MsW-1:0];
        RegTiltMin:     cfg_d.tilt_min_code       = pwdata[CodeW-1:0];
        RegTiltMax:     cfg_d.tilt_max_code       = pwdata[CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegThreshold:   prdata = DataW'(cfg_q.balance_threshold);
      RegIdleTimeout: prdata = DataW'(cfg_q.idle_timeout_ms);
      RegArmDelay:    prdata = DataW'(cfg_q.button_arm_delay_ms);
      RegButtonHold:  prdata = DataW'(cfg_q.button_hold_ms);
      RegMaxAwake:    prdata = DataW'(cfg_q.max_awake_ms);
      RegTiltMin:     prdata = DataW'(cfg_q.tilt_min_code);
      RegTiltMax:     prdata = DataW'(cfg_q.tilt_max_code);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.balance_threshold   <= ThreshReset;
      cfg_q.idle_timeout_ms     <= IdleReset;
      cfg_q.button_arm_delay_ms <= ArmDelayReset;
      cfg_q.button_hold_ms      <= HoldReset;
      cfg_q.max_awake_ms        <= MaxAwakeReset;
      cfg_q.tilt_min_code       <= TiltMinReset;
      cfg_q.tilt_max_code       <= TiltMaxReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[hdl/fsst_core.sv]
// ----------------------------------------------------------------------------
// fsst_core - tracker step logic and tracker state
// pan and tilt decisions, button latch, timers and sleep check
// ----------------------------------------------------------------------------
module fsst_core #(
  parameter int unsigned SAMPLE_BITS = fsst_pkg::DefSampleBits,
  parameter int unsigned TIME_BITS   = fsst_pkg::DefTimeBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  fsst_pkg::in_item_t  item_i,
  input  fsst_pkg::cfg_t      cfg_i,
  output fsst_pkg::out_item_t result_o
);
  import fsst_pkg::*;

  localparam int unsigned PairW = SAMPLE_BITS + 1;
  localparam int unsigned SumW  = ((PairW > ThreshW) ? PairW : ThreshW) + 1;

  logic [SAMPLE_BITS-1:0] ul, dl, ur, dr;
  logic [SumW-1:0]        right, left, up, down, th;
  logic [TIME_BITS-1:0]   now;
  logic                   pressed;

  logic [CodeW-1:0]     tilt_q, tilt_d;
  logic [TIME_BITS-1:0] last_q, last_d, awake_q, awake_d;
  logic [TIME_BITS-1:0] arm_q, arm_d, press_q, press_d;
  logic                 armed_q, armed_d, latch_q, latch_d;

  logic                 pan_r, pan_l, tilt_dn, tilt_up, tilt_moved;
  logic [TIME_BITS-1:0] last_m, press_m;
  logic                 armed_m, idle, btn, awake;
  sleep_cause_e         cause;
  logic [CodeW-1:0]     pan;

  assign ul      = SAMPLE_BITS'(item_i.upper_left_level);
  assign dl      = SAMPLE_BITS'(item_i.lower_left_level);
  assign ur      = SAMPLE_BITS'(item_i.upper_right_level);
  assign dr      = SAMPLE_BITS'(item_i.lower_right_level);
  assign now     = TIME_BITS'(item_i.now_ms);
  assign pressed = !item_i.button_level;

  assign right = SumW'(ur) + SumW'(dr);
  assign left  = SumW'(ul) + SumW'(dl);
  assign up    = SumW'(ul) + SumW'(ur);
  assign down  = SumW'(dl) + SumW'(dr);
  assign th    = SumW'(cfg_i.balance_threshold);

  always_comb begin
    pan_r   = right > (left + th);
    pan_l   = !pan_r && ((right + th) < left);
    tilt_dn = up > (down + th);
    tilt_up = !tilt_dn && ((up + th) < down);

    if (pan_r) begin
      pan = PanRight;
    end else if (pan_l) begin
      pan = PanLeft;
    end else begin
      pan = PanStop;
    end

    tilt_d     = tilt_q;
    tilt_moved = 1'b0;
    if (tilt_dn && (tilt_q > cfg_i.tilt_min_code)) begin
      tilt_d     = tilt_q - CodeW'(1);
      tilt_moved = 1'b1;
    end else if (tilt_up && (tilt_q < cfg_i.tilt_max_code)) begin
      tilt_d     = tilt_q + CodeW'(1);
      tilt_moved = 1'b1;
    end

    last_m  = (pan_r || pan_l || tilt_moved) ? now : last_q;
    press_m = tilt_moved ? now : press_q;
    armed_m = armed_q || ((now - arm_q) > TIME_BITS'(cfg_i.button_arm_delay_ms));

    latch_d = latch_q;
    if (pressed && !latch_q) begin
      press_m = now;
      latch_d = 1'b1;
    end else if (!pressed) begin
      latch_d = 1'b0;
    end

    idle  = (now - last_m) >= TIME_BITS'(cfg_i.idle_timeout_ms);
    btn   = pressed && armed_m && ((now - press_m) >= TIME_BITS'(cfg_i.button_hold_ms));
    awake = (now - awake_q) >= TIME_BITS'(cfg_i.max_awake_ms);

    if (idle) begin
      cause = CauseIdle;
    end else if (btn) begin
      cause = CauseButton;
    end else if (awake) begin
      cause = CauseAwake;
    end else begin
      cause = CauseNone;
    end

    // a sleep request restarts every timer and disarms the button
    if (cause != CauseNone) begin
      last_d  = now;
      awake_d = now;
      arm_d   = now;
      press_d = now;
      armed_d = 1'b0;
    end else begin
      last_d  = last_m;
      awake_d = awake_q;
      arm_d   = arm_q;
      press_d = press_m;
      armed_d = armed_m;
    end
  end

  assign result_o.pan_code      = pan;
  assign result_o.tilt_code     = tilt_d;
  assign result_o.sleep_request = (cause != CauseNone);
  assign result_o.sleep_cause   = cause;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q  <= TiltReset;
      last_q  <= '0;
      awake_q <= '0;
      arm_q   <= '0;
      press_q <= '0;
      armed_q <= 1'b0;
      latch_q <= 1'b0;
    end else if (step_i) begin
      tilt_q  <= tilt_d;
      last_q  <= last_d;
      awake_q <= awake_d;
      arm_q   <= arm_d;
      press_q <= press_d;
      armed_q <= armed_d;
      latch_q <= latch_d;
    end
  end

endmodule

[hdl/four_sensor_sun_tracker_control.sv]
// ----------------------------------------------------------------------------
// four_sensor_sun_tracker_control - dual-axis sun tracker control
// servo codes and sleep requests from four light sensor samples per item
// ----------------------------------------------------------------------------
// usage:
//   input channel: one transaction carries four sensor samples, the button
//   pin level and a millisecond timestamp (in_valid_i / in_stall_o)
//   output channel: one transaction per input transaction with the pan code,
//   the tilt code and the sleep request and cause (out_valid_o / out_stall_i)
//   config: apb-style port, registers at byte address 4*i, pready always
//   high, writes only while no transaction is in flight
// order: the input register loads at the accepting edge, and the result
//   register loads from it once the result register is free
// throughput: one transaction per cycle while the output is not stalled,
//   set by the combinational state update between input and result register
// reset: registers take their defaults, tilt starts at 125, all timers and
//   the button latch clear, both pipeline stages empty
// stall: a stalled result holds; the input register still fills, and only
//   when both stages are full is the input stalled
// ----------------------------------------------------------------------------
module four_sensor_sun_tracker_control #(
  parameter int unsigned SAMPLE_BITS = fsst_pkg::DefSampleBits,
  parameter int unsigned TIME_BITS   = fsst_pkg::DefTimeBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  fsst_pkg::in_item_t         in_data_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output fsst_pkg::out_item_t        out_data_o,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fsst_pkg::AddrW-1:0] paddr,
  input  logic [fsst_pkg::DataW-1:0] pwdata,
  output logic [fsst_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import fsst_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      s1_valid_q, s1_valid_d;
  out_item_t out_q, result;
  logic      out_valid_q, out_valid_d;
  logic      advance, in_take, step;

  // the result register frees when it is empty or being taken
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  // the input register refills in the same cycle that it drains
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  fsst_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // tracker state advances exactly when a transaction moves to the output
  fsst_core #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

`ifndef SYNTHESIS
  // an accepted transaction always lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> s1_valid_q)
    else $error("accepted transaction not held in input register");

  // a processed transaction shows up as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("processed transaction missing at output");

  // the request flag and the cause agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.sleep_request == (out_data_o.sleep_cause != CauseNone)))
    else $error("sleep request and cause disagree");

  // pan code is one of the three pan servo codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pan_code == PanRight || out_data_o.pan_code == PanLeft
                     || out_data_o.pan_code == PanStop))
    else $error("pan code out of set");
`endif

endmodule
